/* hdl/spq_pkg.sv */
// Shared types and constants for the strict-priority three-queue core.
// No dependencies; the controller, datapath and top level import this package.
`default_nettype none

package spq_pkg;

  localparam int NUM_CLASSES   = 3;
  localparam int CLASS_W       = 2;
  localparam int CODE_FIELD_W  = 16;
  localparam int COUNT_FIELD_W = 5;

  // Item opcodes
  localparam logic FUNC_ENQ  = 1'b0;
  localparam logic FUNC_CALL = 1'b1;

  // Class code that names no queue
  localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the accepted input beat
    logic exec;     // apply the captured item to the queues
    logic capture;  // take the dequeued code from the store
  } spq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rd_pending;  // the executing call dequeues an entry
  } spq_sts_t;

endpackage

`default_nettype wire

/* hdl/spq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/spq_ctrl.sv */
// Controller state machine for the strict-priority three-queue core.
// Depends on spq_pkg for the command and status structs.
`default_nettype none

module spq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output spq_pkg::spq_cmd_t      cmd_o,
  input  wire spq_pkg::spq_sts_t sts_i
);
  import spq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0] state_q, state_d;
  logic       in_fire;

  // A new beat may enter while the finished result leaves
  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_ready_i);
  assign out_valid_o = (state_q == ST_RESP);
  assign in_fire     = in_valid_i && in_ready_o;

  assign cmd_o.load    = in_fire;
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.capture = (state_q == ST_READ);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = sts_i.rd_pending ? ST_READ : ST_RESP;
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end else if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_read_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_RESP))
    else $error("read state not followed by response");

endmodule

`default_nettype wire

/* hdl/spq_dp.sv */
// Datapath: item register, per-class ring pointers and counts, entry store, result register.
// Depends on spq_pkg and spq_ram.
`default_nettype none

module spq_dp #(
  parameter int DEPTH      = 16,
  parameter int CODE_WIDTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire spq_pkg::spq_cmd_t                    cmd_i,
  output spq_pkg::spq_sts_t                         sts_o,
  input  wire logic                                 func_i,
  input  wire logic [spq_pkg::CODE_FIELD_W-1:0]     client_code_i,
  input  wire logic [spq_pkg::CLASS_W-1:0]          service_class_i,
  output logic                                      served_valid_o,
  output logic      [spq_pkg::CODE_FIELD_W-1:0]     served_code_o,
  output logic      [spq_pkg::CLASS_W-1:0]          served_class_o,
  output logic                                      overflow_o,
  output logic      [spq_pkg::COUNT_FIELD_W-1:0]    count_class0_o,
  output logic      [spq_pkg::COUNT_FIELD_W-1:0]    count_class1_o,
  output logic      [spq_pkg::COUNT_FIELD_W-1:0]    count_class2_o
);
  import spq_pkg::*;

  localparam int PTR_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int RAM_D    = NUM_CLASSES * DEPTH;
  localparam int ADDR_W   = $clog2(RAM_D);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Item register
  logic                    func_q;
  logic [CODE_FIELD_W-1:0] code_q;
  logic [CLASS_W-1:0]      cls_q;

  // Queue state
  logic [PTR_W-1:0] head_q [NUM_CLASSES];
  logic [PTR_W-1:0] tail_q [NUM_CLASSES];
  logic [CNT_W-1:0] occ_q  [NUM_CLASSES];

  // Result register
  logic                    served_valid_q;
  logic [CLASS_W-1:0]      served_class_q;
  logic                    overflow_q;
  logic [CODE_FIELD_W-1:0] served_code_q;

  logic [NUM_CLASSES-1:0] full;
  logic [NUM_CLASSES-1:0] busy;
  logic [NUM_CLASSES-1:0] enq_hit;
  logic [NUM_CLASSES-1:0] deq_hit;
  logic                   any_busy;
  logic                   call_hit;
  logic                   enq_drop;
  logic [CLASS_W-1:0]     sel_cls;
  logic [PTR_W-1:0]       wptr;
  logic [PTR_W-1:0]       rptr;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr;
  logic [CODE_WIDTH-1:0]  wdata;
  logic [CODE_WIDTH-1:0]  rdata;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] ring_used(input logic [PTR_W-1:0] t,
                                                 input logic [PTR_W-1:0] h);
    ring_used = (t >= h) ? CNT_W'(t) - CNT_W'(h) : CNT_W'(t) + CNT_W'(DEPTH) - CNT_W'(h);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      code_q <= client_code_i;
      cls_q  <= service_class_i;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      full[i] = (occ_q[i] == CNT_FULL);
      busy[i] = (occ_q[i] != '0);
    end
  end

  assign any_busy = |busy;
  assign call_hit = (func_q == FUNC_CALL) && any_busy;
  assign sts_o.rd_pending = call_hit;

  // Priority pick: lowest class number that holds an entry
  always_comb begin
    sel_cls = CLASS_W'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (busy[i]) sel_cls = CLASS_W'(i);
    end
  end

  always_comb begin
    wptr     = '0;
    rptr     = '0;
    enq_drop = 1'b0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      enq_hit[i] = cmd_i.exec && (func_q == FUNC_ENQ) && (cls_q == CLASS_W'(i)) && !full[i];
      deq_hit[i] = cmd_i.exec && call_hit && (sel_cls == CLASS_W'(i));
      if (cls_q == CLASS_W'(i)) begin
        wptr     = tail_q[i];
        enq_drop = (func_q == FUNC_ENQ) && full[i];
      end
      if (sel_cls == CLASS_W'(i)) rptr = head_q[i];
    end
  end

  assign waddr = ADDR_W'(cls_q) * ADDR_W'(DEPTH) + ADDR_W'(wptr);
  assign raddr = ADDR_W'(sel_cls) * ADDR_W'(DEPTH) + ADDR_W'(rptr);
  assign wdata = CODE_WIDTH'(code_q);

  spq_ram #(
    .WIDTH (CODE_WIDTH),
    .DEPTH (RAM_D)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (|enq_hit),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (|deq_hit),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (enq_hit[i]) begin
          tail_q[i] <= ptr_next(tail_q[i]);
          occ_q[i]  <= occ_q[i] + CNT_W'(1);
        end else if (deq_hit[i]) begin
          head_q[i] <= ptr_next(head_q[i]);
          occ_q[i]  <= occ_q[i] - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      served_valid_q <= 1'b0;
      served_class_q <= '0;
      overflow_q     <= 1'b0;
    end else if (cmd_i.load) begin
      // drop the old result so flags always match the held item
      served_valid_q <= 1'b0;
      served_class_q <= '0;
      overflow_q     <= 1'b0;
    end else if (cmd_i.exec) begin
      served_valid_q <= call_hit;
      served_class_q <= call_hit ? sel_cls : '0;
      overflow_q     <= enq_drop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      served_code_q <= '0;
    end else if (cmd_i.capture) begin
      served_code_q <= CODE_FIELD_W'(rdata);
    end
  end

  assign served_valid_o = served_valid_q;
  assign served_code_o  = served_code_q;
  assign served_class_o = served_class_q;
  assign overflow_o     = overflow_q;
  assign count_class0_o = COUNT_FIELD_W'(occ_q[0]);
  assign count_class1_o = COUNT_FIELD_W'(occ_q[1]);
  assign count_class2_o = COUNT_FIELD_W'(occ_q[2]);

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q[0] <= CNT_FULL) && (occ_q[1] <= CNT_FULL) && (occ_q[2] <= CNT_FULL))
    else $error("queue occupancy above depth");

  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_used(tail_q[0], head_q[0]) == (full[0] ? '0 : occ_q[0])) &&
    (ring_used(tail_q[1], head_q[1]) == (full[1] ? '0 : occ_q[1])) &&
    (ring_used(tail_q[2], head_q[2]) == (full[2] ? '0 : occ_q[2])))
    else $error("ring pointers disagree with occupancy");

  a_flags_match_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (served_valid_q |-> (func_q == FUNC_CALL)) and (overflow_q |-> (func_q == FUNC_ENQ)))
    else $error("result flag does not match item opcode");

endmodule

`default_nettype wire

/* hdl/strict_priority_three_queue_core.sv */
// An accepted enqueue beat, and a call that finds every queue empty, passes through the
// EXEC state and then presents its result beat in RESP; a call that dequeues passes
// through EXEC, READ and RESP, where READ is the registered read of the shared entry store.
// A new item enters only in IDLE, or in RESP as the result leaves with out_ready_i high.
// Reset (rst_ni low, asynchronous) empties all queues and the controller; entry
// contents are left as they are and no clearing pass runs.
`default_nettype none

module strict_priority_three_queue_core #(
  parameter int DEPTH      = 16,
  parameter int CODE_WIDTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 func_i,
  input  wire logic [spq_pkg::CODE_FIELD_W-1:0]     client_code_i,
  input  wire logic [spq_pkg::CLASS_W-1:0]          service_class_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      served_valid_o,
  output logic      [spq_pkg::CODE_FIELD_W-1:0]     served_code_o,
  output logic      [spq_pkg::CLASS_W-1:0]          served_class_o,
  output logic                                      overflow_o,
  output logic      [spq_pkg::COUNT_FIELD_W-1:0]    count_class0_o,
  output logic      [spq_pkg::COUNT_FIELD_W-1:0]    count_class1_o,
  output logic      [spq_pkg::COUNT_FIELD_W-1:0]    count_class2_o
);
  import spq_pkg::*;

  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  spq_dp #(
    .DEPTH      (DEPTH),
    .CODE_WIDTH (CODE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .client_code_i   (client_code_i),
    .service_class_i (service_class_i),
    .served_valid_o  (served_valid_o),
    .served_code_o   (served_code_o),
    .served_class_o  (served_class_o),
    .overflow_o      (overflow_o),
    .count_class0_o  (count_class0_o),
    .count_class1_o  (count_class1_o),
    .count_class2_o  (count_class2_o)
  );

endmodule

`default_nettype wire
